// File: rtl/core/tsp_pkg.sv
// Shared widths, codes and sideband types of the trapezoidal speed profile unit.
package tsp_pkg;

  localparam int IN_W    = 24;
  localparam int DIF_W   = IN_W + 1;
  localparam int SQ_W    = 2 * DIF_W;
  localparam int ROOT_W  = DIF_W;
  localparam int SPD_W   = 16;
  localparam int FRAC_W  = 17;
  localparam int GAIN_W  = 16;
  localparam int PEAK_W  = 23;
  localparam int MAG_W   = 22;
  localparam int QUO_W   = 22;
  localparam int NUM_W   = 64;
  localparam int DEN_W   = ROOT_W + FRAC_W;
  localparam int FRAC_SH = 16;

  localparam logic [FRAC_W-1:0] FRAC_ONE       = 17'd65536;
  localparam logic [FRAC_W-1:0] TINY_FRAC      = 17'd7;
  localparam logic [FRAC_W-1:0] LOW_ACCEL_FRAC = 17'd3277;

  localparam logic [1:0] CFG_ACCEL_FRAC = 2'd0;
  localparam logic [1:0] CFG_DECEL_FRAC = 2'd1;
  localparam logic [1:0] CFG_PEAK_GAIN  = 2'd2;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_END    = 2'd3
  } phase_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] v0;
    logic signed [SPD_W-1:0] v1;
    logic                    bad;
  } sq_side_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] base;
    logic                    neg;
    phase_t                  ph;
    logic                    bad;
    logic                    zero;
  } div_side_t;

endpackage

// File: rtl/core/tsp_sqrt_pipe.sv
// Two pipelined integer square roots, one result bit per stage, with sideband.
module tsp_sqrt_pipe #(
  parameter int SIDE_W = 33
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [SIDE_W-1:0]             in_side,
  input  logic [tsp_pkg::SQ_W-1:0]      in_a,
  input  logic [tsp_pkg::SQ_W-1:0]      in_b,
  output logic                          out_vld,
  output logic [SIDE_W-1:0]             out_side,
  output logic [tsp_pkg::ROOT_W-1:0]    out_ra,
  output logic [tsp_pkg::ROOT_W-1:0]    out_rb
);

  localparam int NS = tsp_pkg::ROOT_W;
  localparam int W  = tsp_pkg::SQ_W;

  logic              v_r    [NS];
  logic [SIDE_W-1:0] side_r [NS];
  logic [W-1:0]      ra_r   [NS];
  logic [W-1:0]      rb_r   [NS];
  logic [NS-1:0]     qa_r   [NS];
  logic [NS-1:0]     qb_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    localparam int B = NS - 1 - k;
    logic              v_i;
    logic [SIDE_W-1:0] side_i;
    logic [W-1:0]      ra_i, rb_i, ta, tb;
    logic [NS-1:0]     qa_i, qb_i;

    if (k == 0) begin : g_first
      assign v_i    = in_vld;
      assign side_i = in_side;
      assign ra_i   = in_a;
      assign rb_i   = in_b;
      assign qa_i   = '0;
      assign qb_i   = '0;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign side_i = side_r[k-1];
      assign ra_i   = ra_r[k-1];
      assign rb_i   = rb_r[k-1];
      assign qa_i   = qa_r[k-1];
      assign qb_i   = qb_r[k-1];
    end

    // (q + 2^B)^2 - q^2 = q * 2^(B+1) + 2^(2B)
    assign ta = (W'(qa_i) << (B + 1)) | (W'(1) << (2 * B));
    assign tb = (W'(qb_i) << (B + 1)) | (W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_i;
        if (ra_i >= ta) begin
          ra_r[k] <= ra_i - ta;
          qa_r[k] <= qa_i | (NS'(1) << B);
        end else begin
          ra_r[k] <= ra_i;
          qa_r[k] <= qa_i;
        end
        if (rb_i >= tb) begin
          rb_r[k] <= rb_i - tb;
          qb_r[k] <= qb_i | (NS'(1) << B);
        end else begin
          rb_r[k] <= rb_i;
          qb_r[k] <= qb_i;
        end
      end
    end
  end

  assign out_vld  = v_r[NS-1];
  assign out_side = side_r[NS-1];
  assign out_ra   = qa_r[NS-1];
  assign out_rb   = qb_r[NS-1];

endmodule

// File: rtl/core/tsp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module tsp_div_pipe #(
  parameter int SIDE_W = 21
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [SIDE_W-1:0]           in_side,
  input  logic [tsp_pkg::NUM_W-1:0]   in_num,
  input  logic [tsp_pkg::DEN_W-1:0]   in_den,
  output logic                        out_vld,
  output logic [SIDE_W-1:0]           out_side,
  output logic [tsp_pkg::QUO_W-1:0]   out_quo
);

  localparam int NS = tsp_pkg::QUO_W;
  localparam int W  = tsp_pkg::NUM_W;
  localparam int DW = tsp_pkg::DEN_W;

  logic              v_r    [NS];
  logic [SIDE_W-1:0] side_r [NS];
  logic [W-1:0]      rem_r  [NS];
  logic [DW-1:0]     den_r  [NS];
  logic [NS-1:0]     q_r    [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    localparam int B = NS - 1 - k;
    logic              v_i;
    logic [SIDE_W-1:0] side_i;
    logic [W-1:0]      rem_i, dsh;
    logic [DW-1:0]     den_i;
    logic [NS-1:0]     q_i;

    if (k == 0) begin : g_first
      assign v_i    = in_vld;
      assign side_i = in_side;
      assign rem_i  = in_num;
      assign den_i  = in_den;
      assign q_i    = '0;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign side_i = side_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign den_i  = den_r[k-1];
      assign q_i    = q_r[k-1];
    end

    assign dsh = W'(den_i) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_i;
        den_r[k]  <= den_i;
        if (rem_i >= dsh) begin
          rem_r[k] <= rem_i - dsh;
          q_r[k]   <= q_i | (NS'(1) << B);
        end else begin
          rem_r[k] <= rem_i;
          q_r[k]   <= q_i;
        end
      end
    end
  end

  assign out_vld  = v_r[NS-1];
  assign out_side = side_r[NS-1];
  assign out_quo  = q_r[NS-1];

endmodule

// File: rtl/core/trapezoidal_speed_profile_unit.sv
// Top level of the trapezoidal speed profile unit: distances, phase select, ramp.
//
// Usage: the in_ channel takes one request per cycle unless stalled (position,
// segment start and goal, entry and exit speed); the out_ channel returns one
// result per request, in order: commanded speed, phase and the bad-setup flag.
// The cfg_ port writes accel_fraction (0), decel_fraction (1), peak_gain (2);
// others ignored. Write only while no request is in flight; the block never checks.
// Throughput: one request per cycle unless the output stalls, set by a fully
// pipelined datapath: 3 stages of differences, squares and sums, 25
// square-root stages (one root bit each), 4 stages of products, phase
// select and ramp setup, 22 divider stages (one quotient bit each) and
// the output register.
// Reset: clears every valid bit and loads the register reset values; the
// unit takes requests in the first cycle after reset.
// Stall: when out_ready is low with a result waiting, the whole pipeline
// holds and in_ready drops; nothing is lost or repeated.
module trapezoidal_speed_profile_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_start_x,
  input  logic signed [23:0] in_start_y,
  input  logic signed [23:0] in_goal_x,
  input  logic signed [23:0] in_goal_y,
  input  logic signed [15:0] in_entry_speed,
  input  logic signed [15:0] in_exit_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_speed_cmd,
  output logic [1:0]         out_phase,
  output logic               out_bad_setup
);

  localparam int DIF_W  = tsp_pkg::DIF_W;
  localparam int SQ_W   = tsp_pkg::SQ_W;
  localparam int ROOT_W = tsp_pkg::ROOT_W;
  localparam int SPD_W  = tsp_pkg::SPD_W;
  localparam int FRAC_W = tsp_pkg::FRAC_W;
  localparam int GAIN_W = tsp_pkg::GAIN_W;
  localparam int PEAK_W = tsp_pkg::PEAK_W;
  localparam int MAG_W  = tsp_pkg::MAG_W;
  localparam int QUO_W  = tsp_pkg::QUO_W;
  localparam int NUM_W  = tsp_pkg::NUM_W;
  localparam int DEN_W  = tsp_pkg::DEN_W;
  localparam int GP_W   = GAIN_W + ROOT_W;
  localparam int PRD_W  = MAG_W + ROOT_W;
  localparam int SUM_W  = QUO_W + 2;

  logic en;

  // configuration registers
  logic [FRAC_W-1:0] acc_frac_r, dec_frac_r;
  logic [GAIN_W-1:0] gain_r;
  logic [FRAC_W-1:0] a_sat, d_sat, nd_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_frac_r <= 17'd26214;
      dec_frac_r <= 17'd26214;
      gain_r     <= 16'd29491;
    end else if (cfg_we) begin
      case (cfg_index)
        tsp_pkg::CFG_ACCEL_FRAC: acc_frac_r <= cfg_wdata;
        tsp_pkg::CFG_DECEL_FRAC: dec_frac_r <= cfg_wdata;
        tsp_pkg::CFG_PEAK_GAIN:  gain_r     <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign a_sat  = (acc_frac_r > tsp_pkg::FRAC_ONE) ? tsp_pkg::FRAC_ONE : acc_frac_r;
  assign d_sat  = (dec_frac_r > tsp_pkg::FRAC_ONE) ? tsp_pkg::FRAC_ONE : dec_frac_r;
  assign nd_sat = tsp_pkg::FRAC_ONE - d_sat;

  // stage 1: differences and error check
  logic                    s1_v_r;
  logic signed [DIF_W-1:0] s1_rx_r, s1_ry_r, s1_tx_r, s1_ty_r;
  logic signed [SPD_W-1:0] s1_v0_r, s1_v1_r;
  logic                    s1_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rx_r  <= DIF_W'(in_goal_x) - DIF_W'(in_pos_x);
      s1_ry_r  <= DIF_W'(in_goal_y) - DIF_W'(in_pos_y);
      s1_tx_r  <= DIF_W'(in_goal_x) - DIF_W'(in_start_x);
      s1_ty_r  <= DIF_W'(in_goal_y) - DIF_W'(in_start_y);
      s1_v0_r  <= in_entry_speed;
      s1_v1_r  <= in_exit_speed;
      s1_bad_r <= (in_exit_speed > in_entry_speed) && (a_sat < tsp_pkg::LOW_ACCEL_FRAC);
    end
  end

  // stage 2: squares
  logic                    s2_v_r;
  logic [SQ_W-2:0]         s2_rx_r, s2_ry_r, s2_tx_r, s2_ty_r;
  tsp_pkg::sq_side_t       s2_side_r;
  logic signed [SQ_W-1:0]  p_rx, p_ry, p_tx, p_ty;

  assign p_rx = s1_rx_r * s1_rx_r;
  assign p_ry = s1_ry_r * s1_ry_r;
  assign p_tx = s1_tx_r * s1_tx_r;
  assign p_ty = s1_ty_r * s1_ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rx_r        <= p_rx[SQ_W-2:0];
      s2_ry_r        <= p_ry[SQ_W-2:0];
      s2_tx_r        <= p_tx[SQ_W-2:0];
      s2_ty_r        <= p_ty[SQ_W-2:0];
      s2_side_r.v0   <= s1_v0_r;
      s2_side_r.v1   <= s1_v1_r;
      s2_side_r.bad  <= s1_bad_r;
    end
  end

  // stage 3: sums of squares
  logic              s3_v_r;
  logic [SQ_W-1:0]   s3_rs_r, s3_ts_r;
  tsp_pkg::sq_side_t s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rs_r   <= SQ_W'(s2_rx_r) + SQ_W'(s2_ry_r);
      s3_ts_r   <= SQ_W'(s2_tx_r) + SQ_W'(s2_ty_r);
      s3_side_r <= s2_side_r;
    end
  end

  // square roots: remaining and total distance
  logic              sq_v;
  tsp_pkg::sq_side_t sq_side;
  logic [ROOT_W-1:0] rem_d, tot_d;

  tsp_sqrt_pipe #(
    .SIDE_W($bits(tsp_pkg::sq_side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s3_v_r),
    .in_side  (s3_side_r),
    .in_a     (s3_rs_r),
    .in_b     (s3_ts_r),
    .out_vld  (sq_v),
    .out_side (sq_side),
    .out_ra   (rem_d),
    .out_rb   (tot_d)
  );

  // stage P1: travelled distance and products
  logic                 p1_v_r;
  logic [ROOT_W-1:0]    p1_trav_r, p1_tot_r;
  logic [GP_W-1:0]      p1_gp_r;
  logic [DEN_W-1:0]     p1_ta_r, p1_tnd_r, p1_td_r;
  tsp_pkg::sq_side_t    p1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_trav_r <= (tot_d >= rem_d) ? tot_d - rem_d : rem_d - tot_d;
      p1_tot_r  <= tot_d;
      p1_gp_r   <= GP_W'(gain_r) * GP_W'(tot_d);
      p1_ta_r   <= DEN_W'(tot_d) * DEN_W'(a_sat);
      p1_tnd_r  <= DEN_W'(tot_d) * DEN_W'(nd_sat);
      p1_td_r   <= DEN_W'(tot_d) * DEN_W'(d_sat);
      p1_side_r <= sq_side;
    end
  end

  // stage P2: peak speed and phase select
  logic                     p2_v_r;
  logic signed [PEAK_W-1:0] p2_peak_r, peak_nxt;
  tsp_pkg::phase_t          p2_ph_r, ph_nxt;
  logic [ROOT_W-1:0]        p2_trav_r, p2_tot_r;
  logic [DEN_W-1:0]         p2_ta_r, p2_td_r;
  tsp_pkg::sq_side_t        p2_side_r;
  logic [GP_W:0]            gp_rnd;
  logic [DEN_W-1:0]         trav_sh;
  logic                     in_acc, in_cru, in_dec;

  assign gp_rnd  = (GP_W + 1)'(p1_gp_r) + (GP_W + 1)'(1 << 19);
  assign trav_sh = DEN_W'(p1_trav_r) << tsp_pkg::FRAC_SH;
  assign in_acc  = (a_sat >= tsp_pkg::TINY_FRAC) && (trav_sh <= p1_ta_r);
  assign in_cru  = trav_sh <= p1_tnd_r;
  assign in_dec  = p1_trav_r <= p1_tot_r;

  always_comb begin
    if (a_sat < tsp_pkg::TINY_FRAC) begin
      peak_nxt = PEAK_W'(p1_side_r.v0);
    end else if (d_sat < tsp_pkg::TINY_FRAC) begin
      peak_nxt = PEAK_W'(p1_side_r.v1);
    end else begin
      peak_nxt = $signed({1'b0, gp_rnd[GP_W:20]});
    end
    if (p1_side_r.bad) begin
      ph_nxt = tsp_pkg::PH_END;
    end else if (in_acc) begin
      ph_nxt = tsp_pkg::PH_ACCEL;
    end else if (in_cru) begin
      ph_nxt = tsp_pkg::PH_CRUISE;
    end else if (in_dec) begin
      ph_nxt = tsp_pkg::PH_DECEL;
    end else begin
      ph_nxt = tsp_pkg::PH_END;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_peak_r <= peak_nxt;
      p2_ph_r   <= ph_nxt;
      p2_trav_r <= p1_trav_r;
      p2_tot_r  <= p1_tot_r;
      p2_ta_r   <= p1_ta_r;
      p2_td_r   <= p1_td_r;
      p2_side_r <= p1_side_r;
    end
  end

  // stage P3: ramp setup
  logic                     p3_v_r;
  logic [MAG_W-1:0]         p3_mag_r;
  logic [ROOT_W-1:0]        p3_dist_r;
  logic [DEN_W-1:0]         p3_den_r;
  tsp_pkg::div_side_t       p3_side_r, side3_nxt;
  logic signed [SPD_W-1:0]  ramp_base, peak_sat;
  logic signed [PEAK_W-1:0] delta, delta_abs;
  logic                     is_acc;

  assign is_acc    = p2_ph_r == tsp_pkg::PH_ACCEL;
  assign ramp_base = is_acc ? p2_side_r.v0 : p2_side_r.v1;
  assign delta     = p2_peak_r - PEAK_W'(ramp_base);
  assign delta_abs = delta[PEAK_W-1] ? -delta : delta;

  always_comb begin
    if (p2_peak_r > PEAK_W'(32767)) begin
      peak_sat = 16'sh7FFF;
    end else if (p2_peak_r < -PEAK_W'(32768)) begin
      peak_sat = -16'sh8000;
    end else begin
      peak_sat = p2_peak_r[SPD_W-1:0];
    end
    side3_nxt.neg = delta[PEAK_W-1];
    side3_nxt.ph  = p2_ph_r;
    side3_nxt.bad = p2_side_r.bad;
    case (p2_ph_r)
      tsp_pkg::PH_ACCEL: begin
        side3_nxt.base = ramp_base;
        side3_nxt.zero = p2_ta_r == '0;
      end
      tsp_pkg::PH_DECEL: begin
        side3_nxt.base = ramp_base;
        side3_nxt.zero = p2_td_r == '0;
      end
      tsp_pkg::PH_CRUISE: begin
        side3_nxt.base = peak_sat;
        side3_nxt.zero = 1'b1;
      end
      default: begin
        side3_nxt.base = '0;
        side3_nxt.zero = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (en) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_mag_r  <= delta_abs[MAG_W-1:0];
      p3_dist_r <= is_acc ? p2_trav_r : p2_tot_r - p2_trav_r;
      p3_den_r  <= is_acc ? p2_ta_r : p2_td_r;
      p3_side_r <= side3_nxt;
    end
  end

  // stage P4: numerator product
  logic               p4_v_r;
  logic [PRD_W-1:0]   p4_prod_r;
  logic [DEN_W-1:0]   p4_den_r;
  tsp_pkg::div_side_t p4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else if (en) begin
      p4_v_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_prod_r <= PRD_W'(p3_mag_r) * PRD_W'(p3_dist_r);
      p4_den_r  <= p3_den_r;
      p4_side_r <= p3_side_r;
    end
  end

  // ramp division
  logic               dv_v;
  tsp_pkg::div_side_t dv_side;
  logic [QUO_W-1:0]   dv_quo;

  tsp_div_pipe #(
    .SIDE_W($bits(tsp_pkg::div_side_t))
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (p4_v_r),
    .in_side  (p4_side_r),
    .in_num   (NUM_W'(p4_prod_r) << tsp_pkg::FRAC_SH),
    .in_den   (p4_den_r),
    .out_vld  (dv_v),
    .out_side (dv_side),
    .out_quo  (dv_quo)
  );

  // output register: apply sign, add base, saturate
  logic signed [SUM_W-1:0] q_signed, spd_sum;
  logic signed [SPD_W-1:0] spd_nxt;
  logic signed [SPD_W-1:0] out_spd_r;
  tsp_pkg::phase_t         out_ph_r;
  logic                    out_bad_r, out_valid_r;

  assign q_signed = dv_side.zero ? '0 :
                    dv_side.neg  ? -SUM_W'(dv_quo) : SUM_W'(dv_quo);
  assign spd_sum  = SUM_W'(dv_side.base) + q_signed;

  always_comb begin
    if (spd_sum > SUM_W'(32767)) begin
      spd_nxt = 16'sh7FFF;
    end else if (spd_sum < -SUM_W'(32768)) begin
      spd_nxt = -16'sh8000;
    end else begin
      spd_nxt = spd_sum[SPD_W-1:0];
    end
  end

  assign en = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_spd_r <= spd_nxt;
      out_ph_r  <= dv_side.ph;
      out_bad_r <= dv_side.bad;
    end
  end

  assign in_ready      = en;
  assign out_valid     = out_valid_r;
  assign out_speed_cmd = out_spd_r;
  assign out_phase     = out_ph_r;
  assign out_bad_setup = out_bad_r;

endmodule

// File: rtl/core/tsp_checker.sv
// Port-level checks of the trapezoidal speed profile unit, bound to the top level.
module tsp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_speed_cmd,
  input logic [1:0]         out_phase,
  input logic               out_bad_setup
);

  // bad setup always reports past-end phase
  a_bad_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_setup) |-> (out_phase == tsp_pkg::PH_END))
    else $error("bad setup without end phase");

  // end phase always commands zero speed
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase == tsp_pkg::PH_END) |-> (out_speed_cmd == 16'sd0))
    else $error("end phase with nonzero speed");

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_speed_cmd)))
    else $error("stalled result changed");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled output blocks new requests
  a_backpress: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while output stalled");

endmodule

bind trapezoidal_speed_profile_unit tsp_checker u_tsp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_speed_cmd (out_speed_cmd),
  .out_phase     (out_phase),
  .out_bad_setup (out_bad_setup)
);

// File: sim/testbench.sv
// Self-checking testbench for the trapezoidal speed profile unit.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         STALL_LIMIT = 3000;
  localparam int         DRAIN_CYCLES = 70;

  typedef struct {
    logic signed [23:0] px, py, sx, sy, gx, gy;
    logic signed [15:0] v0, v1;
  } request_t;

  typedef struct {
    logic signed [15:0] speed;
    tsp_pkg::phase_t    ph;
    logic               bad;
  } speed_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] in_pos_x = '0, in_pos_y = '0, in_start_x = '0, in_start_y = '0;
  logic signed [23:0] in_goal_x = '0, in_goal_y = '0;
  logic signed [15:0] in_entry_speed = '0, in_exit_speed = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_speed_cmd;
  logic [1:0] out_phase;
  logic out_bad_setup;

  // register copies used for prediction
  logic [16:0] accel_frac_q = 17'd26214;
  logic [16:0] decel_frac_q = 17'd26214;
  logic [15:0] gain_q = 16'd29491;

  request_t   pending_reqs[$];
  speed_cmd_t expected_cmds[$];
  request_t   cur_req;
  bit         failed = 1'b0;
  bit         quiet = 1'b0;
  int         send_wait = 0;
  int         recv_wait = 0;
  int         idle_cycles = 0;

  trapezoidal_speed_profile_unit i_dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint seg_len(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    return longint'(root_floor(longint'(dx * dx + dy * dy)));
  endfunction

  function automatic longint ramp_speed(longint base, longint delta, longint d, longint div);
    if (div == 0) return base;
    return base + (delta * d * 65536) / div;
  endfunction

  function automatic speed_cmd_t profile_speed(request_t r);
    speed_cmd_t res;
    longint a, d, rem, tot, trav, peak, spd, v0, v1;
    a = (accel_frac_q > tsp_pkg::FRAC_ONE) ? 65536 : longint'(accel_frac_q);
    d = (decel_frac_q > tsp_pkg::FRAC_ONE) ? 65536 : longint'(decel_frac_q);
    v0 = r.v0;
    v1 = r.v1;
    spd = 0;
    res.ph = tsp_pkg::PH_END;
    res.bad = 1'b0;
    if (v1 > v0 && a < tsp_pkg::LOW_ACCEL_FRAC) begin
      res.bad = 1'b1;
    end else begin
      rem = seg_len(r.gx, r.gy, r.px, r.py);
      tot = seg_len(r.gx, r.gy, r.sx, r.sy);
      trav = (tot >= rem) ? tot - rem : rem - tot;
      peak = (longint'(gain_q) * tot + (64'sd1 << 19)) >>> 20;
      if (a < tsp_pkg::TINY_FRAC) peak = v0;
      else if (d < tsp_pkg::TINY_FRAC) peak = v1;
      if (a >= tsp_pkg::TINY_FRAC && trav * 65536 <= tot * a) begin
        spd = ramp_speed(v0, peak - v0, trav, a * tot);
        res.ph = tsp_pkg::PH_ACCEL;
      end else if (trav * 65536 <= tot * (65536 - d)) begin
        spd = peak;
        res.ph = tsp_pkg::PH_CRUISE;
      end else if (trav <= tot) begin
        spd = ramp_speed(v1, peak - v1, tot - trav, d * tot);
        res.ph = tsp_pkg::PH_DECEL;
      end
    end
    if (spd > 32767) spd = 32767;
    if (spd < -32768) spd = -32768;
    res.speed = spd[15:0];
    return res;
  endfunction

  // driver: one nonblocking update of in_valid per edge
  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        expected_cmds.push_back(profile_speed(cur_req));
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_pos_x <= cur_req.px;
          in_pos_y <= cur_req.py;
          in_start_x <= cur_req.sx;
          in_start_y <= cur_req.sy;
          in_goal_x <= cur_req.gx;
          in_goal_y <= cur_req.gy;
          in_entry_speed <= cur_req.v0;
          in_exit_speed <= cur_req.v1;
          busy = 1'b1;
          send_wait = quiet ? 0 : $urandom_range(0, 15);
        end
      end
      in_valid <= busy;
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    speed_cmd_t exp_cmd;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          $error("result with no request outstanding: speed_cmd %0d", out_speed_cmd);
          failed = 1'b1;
        end else begin
          exp_cmd = expected_cmds.pop_front();
          if (out_speed_cmd !== exp_cmd.speed) begin
            $error("speed_cmd expected %0d actual %0d", exp_cmd.speed, out_speed_cmd);
            failed = 1'b1;
          end
          if (out_phase !== exp_cmd.ph) begin
            $error("phase expected %0d actual %0d", exp_cmd.ph, out_phase);
            failed = 1'b1;
          end
          if (out_bad_setup !== exp_cmd.bad) begin
            $error("bad_setup expected %0d actual %0d", exp_cmd.bad, out_bad_setup);
            failed = 1'b1;
          end
        end
        recv_wait = quiet ? 0 : $urandom_range(0, 15);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_ready <= (recv_wait == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      tsp_pkg::CFG_ACCEL_FRAC: accel_frac_q = val;
      tsp_pkg::CFG_DECEL_FRAC: decel_frac_q = val;
      tsp_pkg::CFG_PEAK_GAIN:  gain_q = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending_reqs.size() > 0 || expected_cmds.size() > 0 || in_valid) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic request_t make_req(int px, int py, int sx, int sy, int gx, int gy,
                                        int v0, int v1);
    request_t r;
    r.px = 24'(px); r.py = 24'(py); r.sx = 24'(sx); r.sy = 24'(sy);
    r.gx = 24'(gx); r.gy = 24'(gy);
    r.v0 = 16'(v0); r.v1 = 16'(v1);
    return r;
  endfunction

  // mostly positions along a segment; some pure noise over the whole field range
  function automatic request_t random_req();
    request_t r;
    int sx, sy, gx, gy, k, v0, v1;
    if ($urandom_range(0, 5) == 0) begin
      r.px = 24'($urandom()); r.py = 24'($urandom());
      r.sx = 24'($urandom()); r.sy = 24'($urandom());
      r.gx = 24'($urandom()); r.gy = 24'($urandom());
      r.v0 = 16'($urandom()); r.v1 = 16'($urandom());
      return r;
    end
    sx = $urandom_range(0, 1 << 22) - (1 << 21);
    sy = $urandom_range(0, 1 << 22) - (1 << 21);
    if ($urandom_range(0, 1)) begin
      gx = $urandom_range(0, 1 << 22) - (1 << 21);
      gy = $urandom_range(0, 1 << 22) - (1 << 21);
    end else begin
      gx = sx + $urandom_range(0, 1 << 17) - (1 << 16);
      gy = sy + $urandom_range(0, 1 << 17) - (1 << 16);
    end
    k = $urandom_range(0, 300);
    v0 = $urandom_range(0, 20000);
    v1 = $urandom_range(0, 20000);
    if ($urandom_range(0, 7) == 0) v0 = -v0;
    if ($urandom_range(0, 7) == 0) v1 = -v1;
    return make_req(sx + (gx - sx) * k / 256 + int'($urandom_range(0, 64)) - 32,
                    sy + (gy - sy) * k / 256 + int'($urandom_range(0, 64)) - 32,
                    sx, sy, gx, gy, v0, v1);
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      pending_reqs.push_back(random_req());
    end
    drain();
    quiet = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, segment ends, zero length, past end
    pending_reqs.push_back(make_req(8388607, 8388607, 8388607, 8388607, -8388608, -8388608,
                                    32767, -32768));
    pending_reqs.push_back(make_req(-8388608, -8388608, -8388608, -8388608, 8388607, 8388607,
                                    -32768, 32767));
    pending_reqs.push_back(make_req(-8388608, 8388607, 8388607, -8388608, -8388608, 8388607,
                                    32767, 32767));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 1000, 500));
    pending_reqs.push_back(make_req(65536, 0, 0, 0, 655360, 0, 0, 0));
    pending_reqs.push_back(make_req(327680, 0, 0, 0, 655360, 0, 4096, 2048));
    pending_reqs.push_back(make_req(600000, 0, 0, 0, 655360, 0, 4096, 2048));
    pending_reqs.push_back(make_req(655360, 0, 0, 0, 655360, 0, 4096, 0));
    pending_reqs.push_back(make_req(-655360, 0, 0, 0, 655360, 0, 4096, 0));
    pending_reqs.push_back(make_req(2000000, 3000000, 0, 0, 655360, 655360, 100, 200));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 3, 4, 2000, 8000));
    pending_reqs.push_back(make_req(8388607, -8388608, 0, 0, 0, 0, -32768, -32768));
    drain();

    run_random(100);

    write_reg(tsp_pkg::CFG_ACCEL_FRAC, 17'd3276);
    write_reg(CFG_UNUSED, 17'd5);
    pending_reqs.push_back(make_req(0, 0, 0, 0, 655360, 0, 100, 200));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 655360, 0, 200, 100));
    drain();
    run_random(70);

    write_reg(tsp_pkg::CFG_ACCEL_FRAC, 17'd3277);
    write_reg(tsp_pkg::CFG_DECEL_FRAC, 17'd0);
    write_reg(tsp_pkg::CFG_PEAK_GAIN, 17'd65535);
    run_random(80);

    write_reg(tsp_pkg::CFG_ACCEL_FRAC, 17'd0);
    write_reg(tsp_pkg::CFG_DECEL_FRAC, 17'd65536);
    write_reg(tsp_pkg::CFG_PEAK_GAIN, 17'd0);
    run_random(80);

    write_reg(tsp_pkg::CFG_ACCEL_FRAC, 17'd131071);
    write_reg(tsp_pkg::CFG_DECEL_FRAC, 17'd131071);
    write_reg(tsp_pkg::CFG_PEAK_GAIN, 17'd40000);
    run_random(80);

    write_reg(tsp_pkg::CFG_ACCEL_FRAC, 17'd6);
    write_reg(tsp_pkg::CFG_DECEL_FRAC, 17'd6);
    run_random(70);

    write_reg(tsp_pkg::CFG_ACCEL_FRAC, 17'd7);
    write_reg(tsp_pkg::CFG_DECEL_FRAC, 17'd7);
    write_reg(tsp_pkg::CFG_PEAK_GAIN, 17'd1);
    run_random(70);

    write_reg(tsp_pkg::CFG_ACCEL_FRAC, 17'd20000);
    write_reg(tsp_pkg::CFG_DECEL_FRAC, 17'd45000);
    write_reg(tsp_pkg::CFG_PEAK_GAIN, 17'd29491);
    run_random(80);

    if (!failed) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
